### src/hml_pkg.sv
// shared constants, codes and tables of the heisenberg metropolis lattice core
// no dependencies
package hml_pkg;

    localparam int LATTICE_SIDE_DEF = 16;
    localparam int SPIN_W   = 16;
    localparam int COORD_IN_W = 4;
    localparam int INVT_W   = 24;
    localparam int RND_W    = 16;
    localparam int DE_W     = 21;
    localparam int MAG_W    = 28;
    localparam int BOND_W   = 30;
    localparam int PROB_W   = 17;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 200;

    localparam logic [INVT_W-1:0] INVT_RESET = 24'd65536;
    localparam logic signed [SPIN_W-1:0] SPIN_ONE = 16'sd16384;
    // log2(e) in q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [1:0] {
        FUNC_PROPOSE = 2'd0,
        FUNC_MEASURE = 2'd1,
        FUNC_FILL    = 2'd2
    } t_func;

    // 2^(-k/16) in q1.16, k = 0..16
    function automatic logic [PROB_W-1:0] pow2_frac(input logic [4:0] k);
        logic [PROB_W-1:0] v;
        case (k)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            5'd16: v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### src/hml_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hml_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/hml_accept.sv
// metropolis acceptance test for a positive energy change: table exp(-de/t) vs random
// depends on hml_pkg
module hml_accept (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [19:0]               i_de,
    input  logic [hml_pkg::INVT_W-1:0] i_inv_temp,
    input  logic [hml_pkg::RND_W-1:0]  i_rnd,
    output logic                      o_done,
    output logic                      o_accept
);
    import hml_pkg::*;

    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic        r_accept;
    logic [43:0] r_a;
    logic [38:0] r_pl;
    logic [38:0] r_ph;
    logic [60:0] r_t;
    logic [PROB_W-1:0] r_pk;
    logic [27:0] r_dp;
    logic [14:0] r_n;

    logic [4:0]        k_idx;
    logic [PROB_W-1:0] pk;
    logic [PROB_W-1:0] pk1;
    logic [PROB_W-1:0] pdiff;
    logic [PROB_W-1:0] v;
    logic [PROB_W-1:0] prob;

    always_comb begin
        k_idx = {1'b0, r_t[45:42]};
        pk    = pow2_frac(k_idx);
        pk1   = pow2_frac(k_idx + 5'd1);
        pdiff = pk - pk1;
        v     = r_pk - PROB_W'(r_dp[27:16]);
        prob  = (r_n >= 15'd17) ? '0 : (v >> r_n[4:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_accept <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                case (r_step)
                    3'd0: r_a  <= 44'(i_de) * 44'(i_inv_temp);
                    3'd1: r_pl <= 39'(r_a[21:0]) * 39'(LOG2E_Q16);
                    3'd2: r_ph <= 39'(r_a[43:22]) * 39'(LOG2E_Q16);
                    3'd3: r_t  <= 61'({r_ph, 22'd0}) + 61'(r_pl);
                    3'd4: begin
                        r_pk <= pk;
                        r_dp <= 28'(pdiff[11:0]) * 28'(r_t[41:26]);
                        r_n  <= r_t[60:46];
                    end
                    default: begin
                        r_accept <= prob >= {1'b0, i_rnd};
                        r_done   <= 1'b1;
                        r_busy   <= 1'b0;
                    end
                endcase
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_accept = r_accept;
endmodule

### src/heisenberg_metropolis_lattice_core.sv
// top level of the heisenberg metropolis lattice core: sequencer, lattice ram, result register
// depends on hml_pkg, hml_ram, hml_accept
//
// The lattice of LATTICE_SIDE^3 three-component q1.14 spins lives in one
// ram with one write port and one registered read port. Proposals and
// measures walk through that single read port: a proposal reads the site
// and its six wrapped neighbours, forms dE with one shared multiplier over
// three components, and, when dE is positive, runs the exp table test
// before writing the site back if accepted. A measure repeats the
// seven-read walk for every site. After reset, and for the fill command, a
// clearing pass writes (1,0,0) into every site, one per cycle, during
// which no word is accepted. Items are handled one at a time; the result
// register lets a new word enter while the previous result still waits on
// the output. The user must write inverse_temperature only at a time the
// core is idle; the core itself does not enforce this.
module heisenberg_metropolis_lattice_core #(
    parameter int LATTICE_SIDE = hml_pkg::LATTICE_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config: inverse_temperature, unsigned q8.16
    input  logic                          i_cfg_we,
    input  logic [hml_pkg::INVT_W-1:0]    i_cfg_wdata,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // site_x[3:0], site_y[7:4], site_z[11:8], new_spin_x[27:12],
    // new_spin_y[43:28], new_spin_z[59:44], random_uniform[75:60]
    input  logic [hml_pkg::IN_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]                    s_tuser,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted[0], energy_change[21:1], mag_sum_x[49:22], mag_sum_y[77:50],
    // mag_sum_z[105:78], bond_sum_x[135:106], bond_sum_y[165:136],
    // bond_sum_z[195:166]
    output logic [hml_pkg::OUT_DATA_W-1:0] m_tdata
);
    import hml_pkg::*;

    localparam int CW      = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int SITES   = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW      = $clog2(SITES);
    localparam int SQ      = LATTICE_SIDE * LATTICE_SIDE;
    localparam int MAGA_W  = (16 + 3 * CW > 29) ? 16 + 3 * CW : 29;
    localparam int BONDA_W = (36 + 3 * CW > 45) ? 36 + 3 * CW : 45;
    localparam int DACC_W  = 38;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_MULT, ST_EVAL,
        ST_CHECK, ST_WAIT, ST_WRITE, ST_DONE
    } t_state;

    // coordinate taken modulo the side, at most eight subtract steps
    function automatic logic [CW-1:0] wrap_in(input logic [COORD_IN_W-1:0] c);
        logic [COORD_IN_W:0] v;
        v = {1'b0, c};
        for (int i = 0; i < 8; i++) begin
            if (v >= (COORD_IN_W+1)'(LATTICE_SIDE)) begin
                v = v - (COORD_IN_W+1)'(LATTICE_SIDE);
            end
        end
        return CW'(v);
    endfunction

    function automatic logic [CW-1:0] c_dec(input logic [CW-1:0] c);
        return (c == '0) ? CW'(LATTICE_SIDE - 1) : c - CW'(1);
    endfunction

    function automatic logic [CW-1:0] c_inc(input logic [CW-1:0] c);
        return (c == CW'(LATTICE_SIDE - 1)) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'(AW'(x) * AW'(SQ) + AW'(y) * AW'(LATTICE_SIDE) + AW'(z));
    endfunction

    t_state r_state;
    logic   r_fill_pend;
    logic [1:0] r_func;
    logic [INVT_W-1:0] r_inv_temp;
    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_cx, r_cy, r_cz;
    logic signed [SPIN_W-1:0] r_new [3];
    logic signed [SPIN_W-1:0] r_ctr [3];
    logic signed [18:0]       r_nb  [3];
    logic [RND_W-1:0] r_rnd;
    logic [2:0] r_phase;
    logic [1:0] r_comp;
    logic signed [35:0] r_prod;
    logic signed [DACC_W-1:0] r_dacc;
    logic signed [MAGA_W-1:0]  r_mag  [3];
    logic signed [BONDA_W-1:0] r_bond [3];
    logic signed [DE_W-1:0] r_de;
    logic r_acc;
    logic r_start;
    logic r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    // ram ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [47:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [47:0]     ram_rdata;

    logic            acc_done;
    logic            acc_result;

    logic signed [16:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [35:0] mul_p;
    logic               last_site;
    logic [1:0]         acc_idx;

    logic signed [23:0]      de_floor;
    logic signed [DE_W-1:0]  de_sat;
    logic [MAG_W-1:0]        mag_out  [3];
    logic [BOND_W-1:0]       bond_out [3];
    logic [OUT_DATA_W-1:0]   res_word;

    logic [COORD_IN_W-1:0] in_x, in_y, in_z;

    assign in_x = s_tdata[3:0];
    assign in_y = s_tdata[7:4];
    assign in_z = s_tdata[11:8];

    // read address of the seven-read walk: center, then -x +x -y +y -z +z
    always_comb begin
        case (r_phase)
            3'd0: ram_raddr = site_addr(r_cx, r_cy, r_cz);
            3'd1: ram_raddr = site_addr(c_dec(r_cx), r_cy, r_cz);
            3'd2: ram_raddr = site_addr(c_inc(r_cx), r_cy, r_cz);
            3'd3: ram_raddr = site_addr(r_cx, c_dec(r_cy), r_cz);
            3'd4: ram_raddr = site_addr(r_cx, c_inc(r_cy), r_cz);
            3'd5: ram_raddr = site_addr(r_cx, r_cy, c_dec(r_cz));
            3'd6: ram_raddr = site_addr(r_cx, r_cy, c_inc(r_cz));
            default: ram_raddr = site_addr(r_cx, r_cy, r_cz);
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = {16'sd0, 16'sd0, SPIN_ONE};
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == ST_WRITE) begin
            ram_we    = r_acc;
            ram_waddr = site_addr(r_cx, r_cy, r_cz);
            ram_wdata = {r_new[2], r_new[1], r_new[0]};
        end
    end

    hml_ram #(
        .WIDTH (48),
        .DEPTH (SITES)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hml_accept u_accept (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_de       (r_de[19:0]),
        .i_inv_temp (r_inv_temp),
        .i_rnd      (r_rnd),
        .o_done     (acc_done),
        .o_accept   (acc_result)
    );

    // shared multiplier: (old - new) * nb for a proposal, spin * nb for a measure
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_comp)
            2'd0, 2'd1, 2'd2: begin
                mul_b = r_nb[r_comp];
                if (r_func == FUNC_PROPOSE) begin
                    mul_a = {r_ctr[r_comp][15], r_ctr[r_comp]}
                          - {r_new[r_comp][15], r_new[r_comp]};
                end else begin
                    mul_a = {r_ctr[r_comp][15], r_ctr[r_comp]};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        acc_idx = r_comp - 2'd1;
        last_site = (r_cx == CW'(LATTICE_SIDE - 1)) && (r_cy == CW'(LATTICE_SIDE - 1))
                 && (r_cz == CW'(LATTICE_SIDE - 1));
    end

    // floor dE and bond sums to q14, saturate them and the mag sums, and build the result word
    always_comb begin
        de_floor = r_dacc[DACC_W-1:14];
        if (de_floor[23:20] == {4{de_floor[23]}}) begin
            de_sat = de_floor[20:0];
        end else begin
            de_sat = {de_floor[23], {(DE_W-1){~de_floor[23]}}};
        end
        for (int i = 0; i < 3; i++) begin
            if (r_mag[i][MAGA_W-1:MAG_W-1] == {(MAGA_W-MAG_W+1){r_mag[i][MAGA_W-1]}}) begin
                mag_out[i] = r_mag[i][MAG_W-1:0];
            end else begin
                mag_out[i] = {r_mag[i][MAGA_W-1], {(MAG_W-1){~r_mag[i][MAGA_W-1]}}};
            end
            if (r_bond[i][BONDA_W-1:BOND_W+13]
                    == {(BONDA_W-BOND_W-13){r_bond[i][BONDA_W-1]}}) begin
                bond_out[i] = r_bond[i][BOND_W+13:14];
            end else begin
                bond_out[i] = {r_bond[i][BONDA_W-1], {(BOND_W-1){~r_bond[i][BONDA_W-1]}}};
            end
        end
        res_word = '0;
        if (r_func == FUNC_PROPOSE) begin
            res_word[0]    = r_acc;
            res_word[21:1] = r_de;
        end else if (r_func == FUNC_MEASURE) begin
            res_word[49:22]   = mag_out[0];
            res_word[77:50]   = mag_out[1];
            res_word[105:78]  = mag_out[2];
            res_word[135:106] = bond_out[0];
            res_word[165:136] = bond_out[1];
            res_word[195:166] = bond_out[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_fill_pend <= 1'b0;
            r_func      <= '0;
            r_inv_temp  <= INVT_RESET;
            r_clr_addr  <= '0;
            r_phase     <= '0;
            r_comp      <= '0;
            r_start     <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                r_inv_temp <= i_cfg_wdata;
            end
            if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(SITES - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= r_fill_pend ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        r_func      <= s_tuser;
                        r_phase     <= '0;
                        r_comp      <= '0;
                        r_dacc      <= '0;
                        r_fill_pend <= 1'b0;
                        r_new[0]    <= s_tdata[27:12];
                        r_new[1]    <= s_tdata[43:28];
                        r_new[2]    <= s_tdata[59:44];
                        r_rnd       <= s_tdata[75:60];
                        for (int i = 0; i < 3; i++) begin
                            r_nb[i]   <= '0;
                            r_mag[i]  <= '0;
                            r_bond[i] <= '0;
                        end
                        case (s_tuser)
                            FUNC_PROPOSE: begin
                                r_cx    <= wrap_in(in_x);
                                r_cy    <= wrap_in(in_y);
                                r_cz    <= wrap_in(in_z);
                                r_state <= ST_READ;
                            end
                            FUNC_MEASURE: begin
                                r_cx    <= '0;
                                r_cy    <= '0;
                                r_cz    <= '0;
                                r_state <= ST_READ;
                            end
                            FUNC_FILL: begin
                                r_fill_pend <= 1'b1;
                                r_clr_addr  <= '0;
                                r_state     <= ST_CLEAR;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_READ: begin
                    // data of the previous phase arrives now
                    if (r_phase == 3'd1) begin
                        r_ctr[0] <= ram_rdata[15:0];
                        r_ctr[1] <= ram_rdata[31:16];
                        r_ctr[2] <= ram_rdata[47:32];
                    end else if (r_phase != 3'd0) begin
                        r_nb[0] <= r_nb[0] + 19'(signed'(ram_rdata[15:0]));
                        r_nb[1] <= r_nb[1] + 19'(signed'(ram_rdata[31:16]));
                        r_nb[2] <= r_nb[2] + 19'(signed'(ram_rdata[47:32]));
                    end
                    r_phase <= r_phase + 3'd1;
                    if (r_phase == 3'd7) begin
                        r_phase <= '0;
                        r_comp  <= '0;
                        r_state <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    if (r_comp != 2'd3) begin
                        r_prod <= mul_p;
                    end
                    if (r_comp != 2'd0) begin
                        if (r_func == FUNC_PROPOSE) begin
                            r_dacc <= r_dacc + DACC_W'(r_prod);
                        end else begin
                            r_bond[acc_idx] <= r_bond[acc_idx] + BONDA_W'(r_prod);
                            r_mag[acc_idx]  <= r_mag[acc_idx] + MAGA_W'(r_ctr[acc_idx]);
                        end
                    end
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd3) begin
                        if (r_func == FUNC_PROPOSE) begin
                            r_state <= ST_EVAL;
                        end else if (last_site) begin
                            r_state <= ST_DONE;
                        end else begin
                            // next site in x, y, z order with z fastest
                            for (int i = 0; i < 3; i++) begin
                                r_nb[i] <= '0;
                            end
                            r_cz <= c_inc(r_cz);
                            if (r_cz == CW'(LATTICE_SIDE - 1)) begin
                                r_cy <= c_inc(r_cy);
                                if (r_cy == CW'(LATTICE_SIDE - 1)) begin
                                    r_cx <= c_inc(r_cx);
                                end
                            end
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_EVAL: begin
                    r_de    <= de_sat;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_de[DE_W-1] || r_de == '0) begin
                        r_acc   <= 1'b1;
                        r_state <= ST_WRITE;
                    end else begin
                        r_start <= 1'b1;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (acc_done) begin
                        r_acc   <= acc_result;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_tdata <= res_word;
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_tdata;
endmodule

### tb/tb_heisenberg_metropolis_lattice_core.sv
// testbench of heisenberg_metropolis_lattice_core: directed and random proposals, measures
// and fills, checked against a scoreboard that keeps its own copy of the lattice
// depends on hml_pkg and the core rtl
module tb_heisenberg_metropolis_lattice_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hml_pkg::*;

    localparam int SIDE = 16;
    localparam int SITES = SIDE * SIDE * SIDE;
    localparam int CYCLE_LIMIT = 3000000;
    // settling wait after the last result; the core writes back before it issues a result
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // lattice predictor and store of expected result words
    class lattice_scoreboard;
        shortint spin[SITES][3];
        logic [INVT_W-1:0] inv_temp;
        logic [OUT_DATA_W-1:0] pending[$];
        int errors;
        int unsigned frac_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
            48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        int fld_lo[8] = '{0, 1, 22, 50, 78, 106, 136, 166};
        int fld_w[8] = '{1, 21, 28, 28, 28, 30, 30, 30};

        function void fill();
            for (int s = 0; s < SITES; s++) begin
                spin[s][0] = 16'sd16384;
                spin[s][1] = 16'sd0;
                spin[s][2] = 16'sd0;
            end
        endfunction

        function int idx(int x, int y, int z);
            return (((x + SIDE) % SIDE) * SIDE + ((y + SIDE) % SIDE)) * SIDE + ((z + SIDE) % SIDE);
        endfunction

        function longint nb_sum(int x, int y, int z, int c);
            return longint'(spin[idx(x-1, y, z)][c]) + spin[idx(x+1, y, z)][c]
                 + spin[idx(x, y-1, z)][c] + spin[idx(x, y+1, z)][c]
                 + spin[idx(x, y, z-1)][c] + spin[idx(x, y, z+1)][c];
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        // q1.16 exp(-de * 1/T) by the power-of-two table
        function longint unsigned accept_prob(longint de);
            longint unsigned a, t, n, f, k, r, v;
            a = longint'(de) * longint'(inv_temp);
            t = a * 64'd94548;
            n = t >> 46;
            f = t & ((64'd1 << 46) - 1);
            k = f >> 42;
            r = (f >> 26) & 64'hFFFF;
            if (n >= 17) return 0;
            v = frac_tab[k] - (((frac_tab[k] - frac_tab[k+1]) * r) >> 16);
            return v >> n;
        endfunction

        function void note_input(logic [1:0] fn, logic [IN_DATA_W-1:0] d);
            logic [OUT_DATA_W-1:0] res;
            shortint nw[3];
            int x, y, z, s;
            longint acc, de, mag[3], bond[3];
            bit acc_ok;
            res = '0;
            x = int'(d[3:0]);
            y = int'(d[7:4]);
            z = int'(d[11:8]);
            nw[0] = d[27:12];
            nw[1] = d[43:28];
            nw[2] = d[59:44];
            if (fn == FUNC_PROPOSE) begin
                s = idx(x, y, z);
                acc = 0;
                for (int c = 0; c < 3; c++)
                    acc += (longint'(spin[s][c]) - nw[c]) * nb_sum(x, y, z, c);
                de = clamp(acc >>> 14, DE_W);
                acc_ok = (de <= 0) || (accept_prob(de) >= d[75:60]);
                if (acc_ok)
                    for (int c = 0; c < 3; c++) spin[s][c] = nw[c];
                res[0] = acc_ok;
                res[21:1] = de[20:0];
            end else if (fn == FUNC_MEASURE) begin
                for (int c = 0; c < 3; c++) begin
                    mag[c] = 0;
                    bond[c] = 0;
                end
                for (int a = 0; a < SIDE; a++)
                    for (int b = 0; b < SIDE; b++)
                        for (int e = 0; e < SIDE; e++)
                            for (int c = 0; c < 3; c++) begin
                                mag[c] += spin[idx(a, b, e)][c];
                                bond[c] += longint'(spin[idx(a, b, e)][c]) * nb_sum(a, b, e, c);
                            end
                for (int c = 0; c < 3; c++) begin
                    mag[c] = clamp(mag[c], MAG_W);
                    bond[c] = clamp(bond[c] >>> 14, BOND_W);
                    res[fld_lo[2+c] +: MAG_W] = mag[c][MAG_W-1:0];
                    res[fld_lo[5+c] +: BOND_W] = bond[c][BOND_W-1:0];
                end
            end else if (fn == FUNC_FILL) begin
                fill();
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] exp_w, mask;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $realtime, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            for (int i = 0; i < 8; i++) begin
                mask = ((OUT_DATA_W'(1) << fld_w[i]) - 1) << fld_lo[i];
                if ((exp_w & mask) !== (got & mask)) begin
                    $display("%0t: field %0d mismatch, expected %h actual %h", $realtime, i,
                             (exp_w & mask) >> fld_lo[i], (got & mask) >> fld_lo[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [INVT_W-1:0] i_cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    lattice_scoreboard sb = new();
    bit no_idle = 1'b0;     // set for the stretch without any gaps
    int unsigned cycles = 0;

    heisenberg_metropolis_lattice_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // result side: random back-pressure, check every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // push one word; valid stays high across back-to-back words
    task automatic send_word(logic [1:0] fn, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                             logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                             logic [15:0] rnd);
        logic [IN_DATA_W-1:0] d;
        d = {4'b0, rnd, sz, sy, sx, z, y, x};
        if (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= fn;
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(fn, d);
    endtask

    // drain, let the core settle, then write 1/T
    task automatic set_inv_temp(logic [INVT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.inv_temp = v;
    endtask

    // spin component: mostly within -1..1 in q1.14, sometimes any 16-bit value
    function automatic logic [15:0] rand_comp();
        if ($urandom_range(15) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic random_proposals(int count);
        logic [15:0] r;
        for (int i = 0; i < count; i++) begin
            // near-uniform random acceptance values, plus the extremes
            r = ($urandom_range(9) == 0) ? {16{1'($urandom_range(1))}} : 16'($urandom);
            send_word(FUNC_PROPOSE, 4'($urandom), 4'($urandom), 4'($urandom),
                      rand_comp(), rand_comp(), rand_comp(), r);
        end
    endtask

    initial begin
        logic [INVT_W-1:0] phase_temp[6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0,
                                              24'd262144, 24'd8192};
        sb.fill();
        sb.inv_temp = INVT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_inv_temp(24'd65536);

        // directed: reset lattice, corners, extreme spins, every func code
        send_word(FUNC_MEASURE, '0, '0, '0, '0, '0, '0, '0);
        send_word(FUNC_PROPOSE, '0, '0, '0, 16'h4000, '0, '0, '0);
        send_word(FUNC_PROPOSE, 4'd15, 4'd15, 4'd15, 16'hC000, '0, '0, 16'hFFFF);
        send_word(FUNC_PROPOSE, 4'd15, 4'd15, 4'd15, 16'hC000, '0, '0, 16'h0000);
        send_word(FUNC_PROPOSE, '0, 4'd15, '0, '0, 16'h4000, '0, 16'h8000);
        send_word(FUNC_PROPOSE, 4'd15, '0, 4'd15, '0, '0, 16'hC000, 16'h0001);
        send_word(FUNC_PROPOSE, 4'd1, 4'd1, 4'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_word(FUNC_PROPOSE, '0, 4'd1, 4'd1, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_word(FUNC_PROPOSE, 4'd1, '0, 4'd1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_word(FUNC_PROPOSE, 4'd1, 4'd1, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234);
        send_word(FUNC_UNUSED, 4'hF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(FUNC_MEASURE, '0, '0, '0, '0, '0, '0, '0);
        send_word(FUNC_FILL, '0, '0, '0, '0, '0, '0, '0);
        send_word(FUNC_PROPOSE, 4'd7, 4'd8, 4'd9, 16'h4000, '0, '0, '0);
        send_word(FUNC_MEASURE, '0, '0, '0, '0, '0, '0, '0);

        // random phases over several temperatures, extremes among them
        foreach (phase_temp[p]) begin
            set_inv_temp(phase_temp[p]);
            no_idle = (p == 2);
            random_proposals(170);
            if (p % 2 == 1) send_word(FUNC_UNUSED, 4'($urandom), 4'($urandom), 4'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom));
            send_word(FUNC_MEASURE, '0, '0, '0, '0, '0, '0, '0);
            if (p == 1 || p == 4) send_word(FUNC_FILL, '0, '0, '0, '0, '0, '0, '0);
        end
        set_inv_temp(24'($urandom_range(24'hFFFFFF, 1)));
        no_idle = 1'b0;
        random_proposals(60);
        send_word(FUNC_MEASURE, '0, '0, '0, '0, '0, '0, '0);

        // drain
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
